// ----- rtl/aes128_ctr_block_cipher_assert.svh -----
// Assertion macros for the AES-128 CTR block.
// Included by the top level; depends on nothing else.
`ifndef AES128_CTR_BLOCK_CIPHER_ASSERT_SVH
`define AES128_CTR_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset
`define AESCTR_ASSERT_NOW(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("aes ctr assertion failed");

// Next-cycle implication under synchronous active-low reset
`define AESCTR_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("aes ctr assertion failed");

`endif

// ----- rtl/aesctr_pkg.sv -----
// Shared types, constants and AES round functions for the AES-128 CTR block.
// No dependencies.
package aesctr_pkg;

    localparam int ROUND_KEY_WORDS = 44;
    localparam int NUM_ROUNDS      = ROUND_KEY_WORDS / 4 - 1;
    localparam int ROUND_W         = $clog2(NUM_ROUNDS + 1);
    localparam int BLOCK_BYTES     = 16;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        restart;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  result_count;
    } aes_out_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_IV_HIGH  = 2'd2,
        REG_IV_LOW   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic last_rnd;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES round; the final round skips the column mix
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last_rnd);
        logic [7:0]   b [BLOCK_BYTES];
        logic [7:0]   t [BLOCK_BYTES];
        logic [7:0]   m [BLOCK_BYTES];
        logic [7:0]   all;
        logic [127:0] r;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            b[i] = SBOX[s[127 - 8 * i -: 8]];
        end
        for (int rr = 0; rr < 4; rr++) begin
            for (int c = 0; c < 4; c++) begin
                t[rr + 4 * c] = b[rr + 4 * ((c + rr) & 3)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+0] = t[4*c+0] ^ all ^ xtime(t[4*c+0] ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c+0]);
        end
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            r[127 - 8 * i -: 8] = last_rnd ? t[i] : m[i];
        end
        return r ^ rk;
    endfunction

    // Next round key from the current one
    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] w3;
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        w3 = rk[31:0];
        t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]} ^ {rcon, 24'h0};
        n0 = rk[127:96] ^ t;
        n1 = rk[95:64] ^ n0;
        n2 = rk[63:32] ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // Keep the leading count bytes, byte 0 in the top bits
    function automatic logic [127:0] byte_mask(input logic [4:0] count);
        logic [127:0] m;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            m[127 - 8 * i -: 8] = ({27'd0, count} > i) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// ----- rtl/aes128_ctr_block_cipher.sv -----
// AES-128 CTR block: one word in, one word out, one round per cycle.
// Each word is loaded, runs ten rounds, then goes to the output register.
// Words pass the single shared round unit one at a time; the next is accepted only once
// the result is loaded for output, and a held result stalls that load until it is taken.
// Round keys are derived on the fly alongside the rounds; no key memory.
// Reset (aresetn low, synchronous) clears key, IV and counter to zero and idles.
module aes128_ctr_block_cipher
    import aesctr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  aes_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output aes_out_t    m_data
);

`include "aes128_ctr_block_cipher_assert.svh"

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic        wr_en;
    reg_idx_t    reg_idx;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[4:3]);

    // Register read
    always_comb begin
        unique case (reg_idx)
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_IV_HIGH:  prdata = iv_high_reg;
            REG_IV_LOW:   prdata = iv_low_reg;
            default:      prdata = '0;
        endcase
    end

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                REG_IV_HIGH:  iv_high_reg  <= pwdata;
                REG_IV_LOW:   iv_low_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    aesctr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    aesctr_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .key     ({key_high_reg, key_low_reg}),
        .iv      ({iv_high_reg, iv_low_reg}),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `AESCTR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `AESCTR_ASSERT_NOW(a_load_not_step, aclk, aresetn, cmd.load, !cmd.step && !cmd.out_load)
    `AESCTR_ASSERT_NOW(a_out_load_free, aclk, aresetn, cmd.out_load, !m_valid || m_ready)

endmodule

// ----- rtl/aesctr_ctrl.sv -----
// Sequencer for the AES-128 CTR block: load, ten rounds, result hand-off.
// Depends on aesctr_pkg.
module aesctr_ctrl import aesctr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t        state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               last_rnd;

    assign last_rnd = (round_reg == ROUND_W'(NUM_ROUNDS));

    // Next state
    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ROUND;
                    round_next = ROUND_W'(1);
                end
            end
            ST_ROUND: begin
                round_next = round_reg + ROUND_W'(1);
                if (last_rnd) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_ROUND: begin
                cmd.step     = 1'b1;
                cmd.last_rnd = last_rnd;
            end
            ST_FINISH: begin
                cmd.out_load = status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

endmodule

// ----- rtl/aesctr_datapath.sv -----
// Datapath of the AES-128 CTR block: counter, round state, key schedule, output.
// Depends on aesctr_pkg.
module aesctr_datapath import aesctr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  dp_cmd_t      cmd,
    output dp_status_t   status,
    input  aes_in_t      s_data,
    input  logic [127:0] key,
    input  logic [127:0] iv,
    output logic         m_valid,
    input  logic         m_ready,
    output aes_out_t     m_data
);

    logic [127:0] ctr_reg, ctr_next;
    logic [127:0] state_reg, state_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] data_reg;
    logic [4:0]   count_reg;
    logic         out_valid_reg, out_valid_next;
    aes_out_t     out_reg, out_next;

    logic [127:0] ctr_sel;
    logic [4:0]   n_clamp;
    logic [127:0] rk_step;
    logic [127:0] masked;

    // Clamp count, pick counter source, derive next round key and mask the result
    always_comb begin
        n_clamp = (s_data.byte_count > 5'd16) ? 5'd16 : s_data.byte_count;
        ctr_sel = s_data.restart ? iv : ctr_reg;
        rk_step = key_step(rk_reg, rcon_reg);
        masked  = (data_reg ^ state_reg) & byte_mask(count_reg);
    end

    // On load set counter, round state and key; on step advance round state and key schedule
    always_comb begin
        ctr_next   = ctr_reg;
        state_next = state_reg;
        rk_next    = rk_reg;
        rcon_next  = rcon_reg;
        if (cmd.load) begin
            ctr_next   = ctr_sel + {127'd0, (n_clamp != 5'd0)};
            state_next = ctr_sel ^ key;
            rk_next    = key;
            rcon_next  = 8'h01;
        end else if (cmd.step) begin
            state_next = aes_round(state_reg, rk_step, cmd.last_rnd);
            rk_next    = rk_step;
            rcon_next  = xtime(rcon_reg);
        end
    end

    // Output register
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_next.result_high  = masked[127:64];
            out_next.result_low   = masked[63:0];
            out_next.result_count = count_reg;
            out_valid_next        = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        rk_reg    <= rk_next;
        rcon_reg  <= rcon_next;
        out_reg   <= out_next;
        if (cmd.load) begin
            data_reg  <= {s_data.data_high, s_data.data_low};
            count_reg <= n_clamp;
        end
    end

endmodule

// ----- tb/sv/tb_aes128_ctr_block_cipher.sv -----
// Self-checking testbench for the AES-128 CTR block: drives words over valid/ready,
// writes key and IV over the APB port and checks each result against a predictor.
// Depends on aesctr_pkg and the aes128_ctr_block_cipher RTL.
module tb_aes128_ctr_block_cipher;
    import aesctr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_WORDS = 1400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    aes_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    aes_out_t    m_data;

    // Predictor state
    logic [127:0] cfg_key = '0;
    logic [127:0] cfg_iv = '0;
    logic [127:0] ctr = '0;
    aes_out_t     expected_words[$];

    int cycle_count = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit done = 1'b0;

    typedef struct {
        aes_in_t  din;
        bit       known;
        aes_out_t dout;
    } vector_t;

    aes128_ctr_block_cipher dut (.*);

    always #5 aclk = ~aclk;

    // Cycle guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] mul2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // FIPS-197 encryption of one block, byte 0 in the top bits
    function automatic logic [127:0] cipher_block(input logic [127:0] key,
                                                  input logic [127:0] blk);
        logic [31:0] w[44];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [7:0]  s[16];
        logic [7:0]  u[16];
        logic [7:0]  a0, a1, a2, a3, x;
        logic [127:0] r;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = key[127 - 32 * i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i - 1];
            if (i % 4 == 0) begin
                t = {SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]}
                    ^ {rc, 24'h0};
                rc = mul2(rc);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ w[i / 4][31 - 8 * (i % 4) -: 8];
        for (int rd = 1; rd <= 10; rd++) begin
            for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
            for (int rr = 0; rr < 4; rr++)
                for (int c = 0; c < 4; c++) u[rr + 4 * c] = s[rr + 4 * ((c + rr) % 4)];
            for (int c = 0; c < 4; c++) begin
                a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
                x = a0 ^ a1 ^ a2 ^ a3;
                if (rd != 10) begin
                    u[4*c]   = a0 ^ x ^ mul2(a0 ^ a1);
                    u[4*c+1] = a1 ^ x ^ mul2(a1 ^ a2);
                    u[4*c+2] = a2 ^ x ^ mul2(a2 ^ a3);
                    u[4*c+3] = a3 ^ x ^ mul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = u[i] ^ w[4 * rd + i / 4][31 - 8 * (i % 4) -: 8];
        end
        for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
        return r;
    endfunction

    // Advance the counter model for one word and return its result
    function automatic aes_out_t ctr_predict(input aes_in_t din);
        aes_out_t     o;
        int           n;
        logic [127:0] m;
        logic [127:0] v;
        n = din.byte_count;
        if (n > 16) n = 16;
        if (din.restart) ctr = cfg_iv;
        o = '0;
        if (n == 0) return o;
        for (int i = 0; i < 16; i++) m[127 - 8 * i -: 8] = (i < n) ? 8'hff : 8'h00;
        v = ({din.data_high, din.data_low} ^ cipher_block(cfg_key, ctr)) & m;
        o.result_high  = v[127:64];
        o.result_low   = v[63:0];
        o.result_count = 5'(n);
        ctr = ctr + 128'd1;
        return o;
    endfunction

    // APB write, idle block only
    task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(8 * int'(idx)); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_KEY_HIGH: cfg_key[127:64] = val;
            REG_KEY_LOW:  cfg_key[63:0]   = val;
            REG_IV_HIGH:  cfg_iv[127:64]  = val;
            default:      cfg_iv[63:0]    = val;
        endcase
    endtask

    // Drop valid, then wait for every result to come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Hold the word until accepted, with optional idle gap ahead
    task automatic send_word(input aes_in_t din, input aes_out_t fixed, input bit known);
        aes_out_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        p = ctr_predict(din);
        if (known) p = fixed;
        expected_words.push_back(p);
        s_valid <= 1'b1;
        s_data  <= din;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic aes_in_t random_word();
        aes_in_t d;
        d.data_high  = {$urandom, $urandom};
        d.data_low   = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       d.byte_count = 5'($urandom_range(31));
            1:       d.byte_count = 5'd16;
            default: d.byte_count = 5'($urandom_range(1, 16));
        endcase
        d.restart = ($urandom_range(19) == 0);
        return d;
    endfunction

    // Receiver: random stall, compare oldest expectation
    always @(posedge aclk) begin
        aes_out_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", m_data);
                end else begin
                    e = expected_words.pop_front();
                    if (e.result_high !== m_data.result_high
                        || e.result_low !== m_data.result_low
                        || e.result_count !== m_data.result_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", e, m_data);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        vector_t  vecs[$];
        vector_t  v;
        aes_out_t z;
        aes_in_t  d;
        int       sent;
        int       phase;
        z = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero key, zero counter, data and byte-count extremes, restarts, zero counts
        v.known = 1'b0; v.dout = '0;
        v.din = '{64'h0, 64'h0, 5'd16, 1'b0}; vecs.push_back(v);
        v.din = '{'1, '1, 5'd16, 1'b0}; vecs.push_back(v);
        v.din = '{'1, '1, 5'd1, 1'b0}; vecs.push_back(v);
        v.din = '{'1, '1, 5'd8, 1'b0}; vecs.push_back(v);
        v.din = '{'1, '1, 5'd9, 1'b0}; vecs.push_back(v);
        v.din = '{'1, '1, 5'd15, 1'b0}; vecs.push_back(v);
        v.din = '{'1, '1, 5'd31, 1'b0}; vecs.push_back(v);
        v.din = '{'1, '1, 5'd17, 1'b1}; vecs.push_back(v);
        v.known = 1'b1;
        v.din = '{'1, '1, 5'd0, 1'b0}; vecs.push_back(v);
        v.din = '{64'h1234, 64'h5678, 5'd0, 1'b1}; vecs.push_back(v);
        v.known = 1'b0;
        v.din = '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd7, 1'b0}; vecs.push_back(v);
        foreach (vecs[i]) send_word(vecs[i].din, vecs[i].dout, vecs[i].known);
        wait_drained();

        // Counter wrap with an all-ones key and an IV one below all ones
        reg_write(REG_KEY_HIGH, '1);
        reg_write(REG_KEY_LOW, '1);
        reg_write(REG_IV_HIGH, '1);
        reg_write(REG_IV_LOW, 64'hffff_ffff_ffff_fffe);
        send_word('{64'h0, 64'h0, 5'd16, 1'b1}, z, 1'b0);
        send_word('{64'h0, 64'h0, 5'd16, 1'b0}, z, 1'b0);
        send_word('{64'h0, 64'h0, 5'd16, 1'b0}, z, 1'b0);
        send_word('{'1, 64'h0, 5'd16, 1'b0}, z, 1'b0);
        wait_drained();

        // Random phases with varying idling and fresh settings
        sent = 0;
        for (phase = 0; phase < 5; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (phase == 4) begin
                reg_write(REG_KEY_HIGH, '0); reg_write(REG_KEY_LOW, '0);
                reg_write(REG_IV_HIGH, '0);  reg_write(REG_IV_LOW, '0);
            end else begin
                reg_write(REG_KEY_HIGH, {$urandom, $urandom});
                reg_write(REG_KEY_LOW, {$urandom, $urandom});
                reg_write(REG_IV_HIGH, {$urandom, $urandom});
                reg_write(REG_IV_LOW, {$urandom, $urandom});
            end
            for (int k = 0; k < RANDOM_WORDS / 5; k++) begin
                d = random_word();
                if (k == 0) d.restart = 1'b1;
                send_word(d, z, 1'b0);
                sent++;
                // Once per phase, after the word with index 50, hold off until every result is back
                if (k == 50) wait_drained();
            end
            wait_drained();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        wait_drained();

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- aes128_ctr_block_cipher.f -----
+incdir+rtl
rtl/aesctr_pkg.sv
rtl/aesctr_ctrl.sv
rtl/aesctr_datapath.sv
rtl/aes128_ctr_block_cipher.sv
tb/sv/tb_aes128_ctr_block_cipher.sv
